/* hdl/maf_pkg.sv */
// Shared constants, types and helpers for the moving average filter
package maf_pkg;

    localparam int MAX_WINDOW   = 64;
    localparam int SAMPLE_WIDTH = 16;
    localparam int SLOT_W       = $clog2(MAX_WINDOW);
    localparam int WIN_W        = SLOT_W + 1;
    localparam int SUM_W        = SAMPLE_WIDTH + SLOT_W;
    localparam int STEP_W       = $clog2(SUM_W);
    localparam int FIFO_DEPTH   = 2;
    localparam int FIFO_PTR_W   = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W   = $clog2(FIFO_DEPTH + 1);

    localparam logic [WIN_W-1:0] WINDOW_RESET = WIN_W'(4);

    typedef logic signed [SAMPLE_WIDTH-1:0] t_sample;
    typedef logic signed [SUM_W-1:0]        t_sum;
    typedef logic        [SUM_W-1:0]        t_mag;
    typedef logic        [WIN_W-1:0]        t_win;
    typedef logic        [SLOT_W-1:0]       t_slot;

    typedef struct packed {
        t_sum sum;
        t_win divisor;
    } t_job;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_DIV  = 3'b010,
        S_HOLD = 3'b100
    } t_div_state;

    function automatic t_win eff_window(input t_win len);
        t_win w;
        if (len == '0) begin
            w = WIN_W'(1);
        end else if (len > WIN_W'(MAX_WINDOW)) begin
            w = WIN_W'(MAX_WINDOW);
        end else begin
            w = len;
        end
        return w;
    endfunction

endpackage

/* hdl/maf_if.sv */
// Valid/ready channel interfaces for samples in and means out
interface maf_sample_if;
    import maf_pkg::*;
    logic    valid;
    logic    ready;
    t_sample sample;
    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface maf_mean_if;
    import maf_pkg::*;
    logic    valid;
    logic    ready;
    t_sample mean;
    modport source (output valid, output mean, input ready);
    modport sink   (input valid, input mean, output ready);
endinterface

/* hdl/moving_average_filter.sv */
// Top level of the moving average filter: window register and unit wiring
//
// Samples arrive on i_sample_ch (valid/ready, signed 16-bit beat); means leave
// on o_mean_ch (valid/ready, signed 16-bit beat), one mean per sample, in order.
// Each mean is the sum of the latest window_len samples divided by window_len,
// truncated toward zero; samples before the first one or before a window
// write count as zero. A window_len of 0 acts as 1, above 64 acts as 64.
// i_cfg_wr_en with i_cfg_wr_data writes window_len and clears the history at
// once; write it only while no beat is in flight.
// The one-bit-per-cycle divider over the 22-bit window sum takes a new sum
// only when idle; meanwhile the front end keeps taking samples until the
// queue fills. A two-entry queue sits between the sum stage and the divider,
// and the output register lets the divider finish while a mean waits.
// When the receiver stalls the mean is held, the divider then holds, the queue
// fills and i_sample_ch.ready drops; nothing is lost.
// Reset (synchronous, active low) clears the history and sets window_len to 4.
module moving_average_filter (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_wr_en,
    input  maf_pkg::t_win       i_cfg_wr_data,
    maf_sample_if.sink          i_sample_ch,
    maf_mean_if.source          o_mean_ch
);
    import maf_pkg::*;

    t_win  r_window_len;
    t_win  window;
    logic  push;
    logic  push_ready;
    t_job  front_job;
    logic  pop_valid;
    t_job  back_job;
    logic  pop;

    assign window = eff_window(r_window_len);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_len <= WINDOW_RESET;
        end else if (i_cfg_wr_en) begin
            r_window_len <= i_cfg_wr_data;
        end
    end

    maf_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_clear      (i_cfg_wr_en),
        .i_window     (window),
        .i_sample_ch  (i_sample_ch),
        .o_push       (push),
        .o_job        (front_job),
        .i_push_ready (push_ready)
    );

    maf_fifo u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_job        (front_job),
        .o_push_ready (push_ready),
        .o_pop_valid  (pop_valid),
        .o_job        (back_job),
        .i_pop        (pop)
    );

    maf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (pop_valid),
        .i_job       (back_job),
        .o_job_ready (pop),
        .o_mean_ch   (o_mean_ch)
    );

endmodule

/* hdl/maf_front.sv */
// Front end: sample ring, window bookkeeping and running sum
module maf_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_clear,
    input  maf_pkg::t_win       i_window,
    maf_sample_if.sink          i_sample_ch,
    output logic                o_push,
    output maf_pkg::t_job       o_job,
    input  logic                i_push_ready
);
    import maf_pkg::*;

    t_sample                r_ring [MAX_WINDOW];
    logic [MAX_WINDOW-1:0]  r_valid;
    t_slot                  r_slot;
    logic                   r_s1_valid;
    t_sample                r_s1_sample;
    t_sample                r_oldest;
    logic                   r_oldest_valid;
    t_sum                   r_sum;
    t_sum                   n_sum;
    t_slot                  leave;
    logic                   accept;
    logic                   pushed;

    assign leave             = r_slot - i_window[SLOT_W-1:0];
    assign i_sample_ch.ready = !r_s1_valid || i_push_ready;
    assign accept            = i_sample_ch.valid && i_sample_ch.ready;
    assign pushed            = r_s1_valid && i_push_ready;

    always_comb begin
        n_sum = r_sum + SUM_W'(r_s1_sample);
        if (r_oldest_valid) begin
            n_sum = n_sum - SUM_W'(r_oldest);
        end
    end

    assign o_push        = r_s1_valid;
    assign o_job.sum     = n_sum;
    assign o_job.divisor = i_window;

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_ring[r_slot] <= i_sample_ch.sample;
            r_oldest       <= r_ring[leave];
            r_s1_sample    <= i_sample_ch.sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_valid        <= '0;
            r_slot         <= '0;
            r_sum          <= '0;
            r_s1_valid     <= 1'b0;
            r_oldest_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_valid[r_slot] <= 1'b1;
                r_slot          <= r_slot + SLOT_W'(1);
                r_oldest_valid  <= r_valid[leave];
                r_s1_valid      <= 1'b1;
            end else if (pushed) begin
                r_s1_valid <= 1'b0;
            end
            if (pushed) begin
                r_sum <= n_sum;
            end
        end
    end

    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_clear |=> (r_sum == '0 && r_slot == '0 && r_valid == '0))
        else $error("history not cleared after window write");

endmodule

/* hdl/maf_fifo.sv */
// Two-entry queue of sum and divisor jobs between front end and divider
module maf_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  maf_pkg::t_job  i_job,
    output logic           o_push_ready,
    output logic           o_pop_valid,
    output maf_pkg::t_job  o_job,
    input  logic           i_pop
);
    import maf_pkg::*;

    t_job                   r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]  r_wr_ptr;
    logic [FIFO_PTR_W-1:0]  r_rd_ptr;
    logic [FIFO_CNT_W-1:0]  r_count;
    logic                   do_push;
    logic                   do_pop;

    assign o_push_ready = r_count != FIFO_CNT_W'(FIFO_DEPTH);
    assign o_pop_valid  = r_count != '0;
    assign o_job        = r_mem[r_rd_ptr];
    assign do_push      = i_push && o_push_ready;
    assign do_pop       = i_pop && o_pop_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + FIFO_PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + FIFO_PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + FIFO_CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - FIFO_CNT_W'(1);
            end
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FIFO_CNT_W'(FIFO_DEPTH))
        else $error("queue overfilled");

    a_empty_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_rd_ptr == r_wr_ptr))
        else $error("queue pointers disagree when empty");

endmodule

/* hdl/maf_back.sv */
// Back end: bit-serial signed divide of the window sum and output register
module maf_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_job_valid,
    input  maf_pkg::t_job  i_job,
    output logic           o_job_ready,
    maf_mean_if.source     o_mean_ch
);
    import maf_pkg::*;

    t_div_state          r_state;
    logic [STEP_W-1:0]   r_count;
    t_mag                r_quo;
    t_win                r_rem;
    t_win                r_div;
    logic                r_neg;
    logic                r_out_valid;
    t_sample             r_out_mean;
    t_mag                mag;
    t_win                shifted;
    logic [WIN_W:0]      trial;
    t_mag                signed_quo;
    logic                take;
    logic                load_out;

    assign o_job_ready = r_state == S_IDLE;
    assign take        = o_job_ready && i_job_valid;
    assign mag         = i_job.sum[SUM_W-1] ? t_mag'(-i_job.sum) : t_mag'(i_job.sum);
    assign shifted     = {r_rem[WIN_W-2:0], r_quo[SUM_W-1]};
    assign trial       = {1'b0, shifted} - {1'b0, r_div};
    assign signed_quo  = r_neg ? (~r_quo + SUM_W'(1)) : r_quo;
    assign load_out    = (r_state == S_HOLD) && (!r_out_valid || o_mean_ch.ready);

    assign o_mean_ch.valid = r_out_valid;
    assign o_mean_ch.mean  = r_out_mean;

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_quo   <= mag;
            r_rem   <= '0;
            r_div   <= i_job.divisor;
            r_neg   <= i_job.sum[SUM_W-1];
        end else if (r_state == S_DIV) begin
            if (!trial[WIN_W]) begin
                r_rem <= trial[WIN_W-1:0];
                r_quo <= {r_quo[SUM_W-2:0], 1'b1};
            end else begin
                r_rem <= shifted;
                r_quo <= {r_quo[SUM_W-2:0], 1'b0};
            end
        end
        if (load_out) begin
            r_out_mean <= signed_quo[SAMPLE_WIDTH-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (take) begin
                        r_count <= '0;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_count <= r_count + STEP_W'(1);
                    if (r_count == STEP_W'(SUM_W - 1)) begin
                        r_state <= S_HOLD;
                    end
                end
                S_HOLD: begin
                    if (load_out) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_mean_ch.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    a_rem_below_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_rem < r_div))
        else $error("partial remainder not below divisor");

    a_step_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_count <= STEP_W'(SUM_W - 1)))
        else $error("divide step count overran");

    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_div != '0))
        else $error("zero divisor in divide");

endmodule
